@@ sv/assert_macros.svh @@
// Assertion helpers for the design file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ sv/i2cbc_pkg.sv @@
package i2cbc_pkg;

    localparam int unsigned TimerW   = 16;
    localparam int unsigned CountW   = 4;
    localparam int unsigned OutcomeW = 3;
    localparam int unsigned TotalW   = 32;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] CFG_SETTLE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HALF    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_STUCK   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_STRETCH = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_PULSES  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0]        RST_SETTLE  = 8'd20;
    localparam logic [7:0]        RST_HALF    = 8'd5;
    localparam logic [TimerW-1:0] RST_STUCK   = 16'd10000;
    localparam logic [TimerW-1:0] RST_STRETCH = 16'd1000;
    localparam logic [CountW-1:0] RST_PULSES  = 4'd9;

    // Outcome codes.
    localparam logic [OutcomeW-1:0] OUT_IDLE      = 3'd0;
    localparam logic [OutcomeW-1:0] OUT_RECOVERED = 3'd1;
    localparam logic [OutcomeW-1:0] OUT_SCL_STUCK = 3'd2;
    localparam logic [OutcomeW-1:0] OUT_SDA_LOW   = 3'd3;
    localparam logic [OutcomeW-1:0] OUT_SCL_LOW   = 3'd4;
    localparam logic [OutcomeW-1:0] OUT_BOTH_LOW  = 3'd5;

    typedef enum logic [9:0] {
        PH_IDLE         = 10'b00_0000_0001,
        PH_SETTLE       = 10'b00_0000_0010,
        PH_STUCK_WAIT   = 10'b00_0000_0100,
        PH_PULSE_LOW    = 10'b00_0000_1000,
        PH_PULSE_WAIT   = 10'b00_0001_0000,
        PH_PULSE_HIGH   = 10'b00_0010_0000,
        PH_STOP_LOW     = 10'b00_0100_0000,
        PH_STOP_WAIT    = 10'b00_1000_0000,
        PH_STOP_HIGH    = 10'b01_0000_0000,
        PH_STOP_RELEASE = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0]        settle;
        logic [7:0]        half;
        logic [TimerW-1:0] stuck;
        logic [TimerW-1:0] stretch;
        logic [CountW-1:0] pulses;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [TimerW-1:0]   timer;
        logic [CountW-1:0]   pulse_count;
        logic                stop_ok;
        logic [OutcomeW-1:0] last_outcome;
        logic [TotalW-1:0]   attempts;
        logic [TotalW-1:0]   failures;
    } t_state;

    typedef struct packed {
        logic                scl_pull_low;
        logic                sda_pull_low;
        logic                busy_res;
        logic                finished;
        logic [OutcomeW-1:0] outcome;
        logic [CountW-1:0]   pulses_given;
        logic [TotalW-1:0]   attempt_total;
        logic [TotalW-1:0]   failure_total;
    } t_result;

endpackage

@@ sv/i2cbc_core.sv @@
module i2cbc_core (
    input  i2cbc_pkg::t_cfg    i_cfg,
    input  i2cbc_pkg::t_state  i_state,
    input  logic               i_start_req,
    input  logic               i_sda_level,
    input  logic               i_scl_level,
    output i2cbc_pkg::t_state  o_state,
    output i2cbc_pkg::t_result o_result
);
    import i2cbc_pkg::*;

    logic [TimerW-1:0]   timer_inc;
    logic                half_done;
    logic                done;
    logic                sda_ok;
    logic                scl_ok;
    logic [OutcomeW-1:0] code;
    logic [CountW-1:0]   pulse_inc;
    t_state              s;

    assign timer_inc = i_state.timer + 1'b1;
    assign half_done = timer_inc >= {{(TimerW-8){1'b0}}, i_cfg.half};
    assign pulse_inc = i_state.pulse_count + 1'b1;
    assign sda_ok    = i_sda_level;
    assign scl_ok    = i_scl_level && i_state.stop_ok;

    always_comb begin
        if (sda_ok && scl_ok) begin
            code = OUT_RECOVERED;
        end else if (!sda_ok && !scl_ok) begin
            code = OUT_BOTH_LOW;
        end else if (!sda_ok) begin
            code = OUT_SDA_LOW;
        end else begin
            code = OUT_SCL_LOW;
        end
    end

    always_comb begin
        s    = i_state;
        done = 1'b0;
        case (i_state.phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    s.attempts    = i_state.attempts + 1'b1;
                    s.pulse_count = '0;
                    s.stop_ok     = 1'b1;
                    s.timer       = '0;
                    s.phase       = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (i_state.timer < {{(TimerW-8){1'b0}}, i_cfg.settle}) begin
                    s.timer = timer_inc;
                end else if (i_sda_level && i_scl_level) begin
                    s.last_outcome = OUT_IDLE;
                    s.phase        = PH_IDLE;
                    s.timer        = '0;
                    done           = 1'b1;
                end else if (!i_scl_level) begin
                    s.timer = '0;
                    s.phase = PH_STUCK_WAIT;
                end else begin
                    s.timer = '0;
                    s.phase = (!i_sda_level && i_state.pulse_count < i_cfg.pulses)
                            ? PH_PULSE_LOW : PH_STOP_LOW;
                end
            end
            PH_STUCK_WAIT: begin
                if (i_scl_level) begin
                    s.timer = '0;
                    s.phase = (!i_sda_level && i_state.pulse_count < i_cfg.pulses)
                            ? PH_PULSE_LOW : PH_STOP_LOW;
                end else if (i_state.timer >= i_cfg.stuck) begin
                    s.last_outcome = OUT_SCL_STUCK;
                    s.failures     = i_state.failures + 1'b1;
                    s.phase        = PH_IDLE;
                    s.timer        = '0;
                    done           = 1'b1;
                end else begin
                    s.timer = timer_inc;
                end
            end
            PH_PULSE_LOW: begin
                s.timer = timer_inc;
                if (half_done) begin
                    s.timer = '0;
                    s.phase = PH_PULSE_WAIT;
                end
            end
            PH_PULSE_WAIT: begin
                if (i_scl_level) begin
                    s.timer = '0;
                    s.phase = PH_PULSE_HIGH;
                end else if (i_state.timer >= i_cfg.stretch) begin
                    s.timer = '0;
                    s.phase = PH_STOP_LOW;
                end else begin
                    s.timer = timer_inc;
                end
            end
            PH_PULSE_HIGH: begin
                s.timer = timer_inc;
                if (half_done) begin
                    s.pulse_count = pulse_inc;
                    s.timer       = '0;
                    s.phase       = (!i_sda_level && pulse_inc < i_cfg.pulses)
                                  ? PH_PULSE_LOW : PH_STOP_LOW;
                end
            end
            PH_STOP_LOW: begin
                s.timer = timer_inc;
                if (half_done) begin
                    s.timer = '0;
                    s.phase = PH_STOP_WAIT;
                end
            end
            PH_STOP_WAIT: begin
                if (i_scl_level) begin
                    s.timer = '0;
                    s.phase = PH_STOP_HIGH;
                end else if (i_state.timer >= i_cfg.stretch) begin
                    s.stop_ok = 1'b0;
                    s.timer   = '0;
                    s.phase   = PH_STOP_HIGH;
                end else begin
                    s.timer = timer_inc;
                end
            end
            PH_STOP_HIGH: begin
                s.timer = timer_inc;
                if (half_done) begin
                    s.timer = '0;
                    s.phase = PH_STOP_RELEASE;
                end
            end
            PH_STOP_RELEASE: begin
                s.timer = timer_inc;
                if (half_done) begin
                    s.last_outcome = code;
                    if (code != OUT_RECOVERED) begin
                        s.failures = i_state.failures + 1'b1;
                    end
                    s.phase = PH_IDLE;
                    s.timer = '0;
                    done    = 1'b1;
                end
            end
            default: begin
                s.phase = PH_IDLE;
                s.timer = '0;
            end
        endcase
    end

    assign o_state = s;

    always_comb begin
        o_result.scl_pull_low  = (s.phase == PH_PULSE_LOW);
        o_result.sda_pull_low  = (s.phase == PH_STOP_LOW) || (s.phase == PH_STOP_WAIT)
                              || (s.phase == PH_STOP_HIGH);
        o_result.busy_res      = (s.phase != PH_IDLE);
        o_result.finished      = done;
        o_result.outcome       = s.last_outcome;
        o_result.pulses_given  = s.pulse_count;
        o_result.attempt_total = s.attempts;
        o_result.failure_total = s.failures;
    end

endmodule

@@ sv/i2cbc_out_reg.sv @@
module i2cbc_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  i2cbc_pkg::t_result i_result,
    input  logic               i_out_ready,
    output logic               o_can_load,
    output logic               o_out_valid,
    output i2cbc_pkg::t_result o_result
);
    import i2cbc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register may be refilled in the same cycle its content is taken.
    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ sv/i2c_bus_clear_sequencer.sv @@
// I2C bus-clear sequencer for an open-drain bus.
// Each input transaction is one time tick carrying a start request and the
// sampled SDA and SCL levels; each tick yields exactly one result transaction
// with the pull-low controls, busy and finished flags, the last outcome, the
// pulse count and the wrapping attempt and failure totals.
// The input channel (i_in_valid / o_in_ready) feeds a state machine whose next
// state is formed in one pass of combinational logic; the result is captured in
// an output register and shown on o_out_valid in the cycle after input acceptance.
// Throughput is one tick per cycle while results are taken, set by the single state
// register update per tick.
// The output register is refilled in the same cycle its transaction is taken,
// so a new tick is accepted whenever the result register is empty or being
// read. While the receiver stalls (i_out_ready low with a result waiting),
// o_in_ready drops and the state machine holds.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes register i_cfg_index with i_cfg_data masked to the register width;
// unknown indexes are dropped. Reset is synchronous and active low; it returns
// the registers to their defaults, the sequencer to idle with zero counters,
// and empties the result register.
module i2c_bus_clear_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [i2cbc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [i2cbc_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_start_req,
    input  logic                               i_sda_level,
    input  logic                               i_scl_level,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_scl_pull_low,
    output logic                               o_sda_pull_low,
    output logic                               o_busy_res,
    output logic                               o_finished,
    output logic [i2cbc_pkg::OutcomeW-1:0]     o_outcome,
    output logic [i2cbc_pkg::CountW-1:0]       o_pulses_given,
    output logic [i2cbc_pkg::TotalW-1:0]       o_attempt_total,
    output logic [i2cbc_pkg::TotalW-1:0]       o_failure_total
);
    import i2cbc_pkg::*;

    `include "assert_macros.svh"

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result out_result;
    logic    can_load;
    logic    in_fire;

    // The user must issue configuration writes only while the sequencer is idle; the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle  <= RST_SETTLE;
            r_cfg.half    <= RST_HALF;
            r_cfg.stuck   <= RST_STUCK;
            r_cfg.stretch <= RST_STRETCH;
            r_cfg.pulses  <= RST_PULSES;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SETTLE:  r_cfg.settle  <= i_cfg_data[7:0];
                CFG_HALF:    r_cfg.half    <= i_cfg_data[7:0];
                CFG_STUCK:   r_cfg.stuck   <= i_cfg_data[TimerW-1:0];
                CFG_STRETCH: r_cfg.stretch <= i_cfg_data[TimerW-1:0];
                CFG_PULSES:  r_cfg.pulses  <= i_cfg_data[CountW-1:0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // One tick is consumed only when its result has room to land.
    assign o_in_ready = can_load;
    assign in_fire    = i_in_valid && can_load;

    i2cbc_core u_core (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_start_req (i_start_req),
        .i_sda_level (i_sda_level),
        .i_scl_level (i_scl_level),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.timer        <= '0;
            r_state.pulse_count  <= '0;
            r_state.stop_ok      <= 1'b1;
            r_state.last_outcome <= OUT_IDLE;
            r_state.attempts     <= '0;
            r_state.failures     <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    i2cbc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_fire),
        .i_result    (n_result),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_scl_pull_low  = out_result.scl_pull_low;
    assign o_sda_pull_low  = out_result.sda_pull_low;
    assign o_busy_res      = out_result.busy_res;
    assign o_finished      = out_result.finished;
    assign o_outcome       = out_result.outcome;
    assign o_pulses_given  = out_result.pulses_given;
    assign o_attempt_total = out_result.attempt_total;
    assign o_failure_total = out_result.failure_total;

    // A completed sequence always leaves the sequencer idle.
    `ASSERT_IMP(a_finish_idle, i_clk, i_rst_n, o_out_valid && o_finished, !o_busy_res)
    // The two lines are never pulled low at the same time.
    `ASSERT_IMP(a_no_dual_pull, i_clk, i_rst_n, o_out_valid && o_scl_pull_low, !o_sda_pull_low)
    // The counters advance only on an accepted tick.
    `ASSERT_NXT(a_attempts_hold, i_clk, i_rst_n, !in_fire, $stable(r_state.attempts))
    `ASSERT_NXT(a_failures_hold, i_clk, i_rst_n, !in_fire, $stable(r_state.failures))

endmodule

@@ sim/i2c_bus_clear_checker.sv @@
`timescale 1ns / 100ps

module i2c_bus_clear_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [i2cbc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [i2cbc_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_start_req,
    input  logic                           i_sda_level,
    input  logic                           i_scl_level,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_scl_pull_low,
    input  logic                           i_sda_pull_low,
    input  logic                           i_busy_res,
    input  logic                           i_finished,
    input  logic [i2cbc_pkg::OutcomeW-1:0] i_outcome,
    input  logic [i2cbc_pkg::CountW-1:0]   i_pulses_given,
    input  logic [i2cbc_pkg::TotalW-1:0]   i_attempt_total,
    input  logic [i2cbc_pkg::TotalW-1:0]   i_failure_total,
    output int                             o_mismatches
);

    import i2cbc_pkg::*;

    // Shadow copy of the sequencer: settings and recovery state.
    t_cfg                 bus_cfg;
    t_phase               bus_phase;
    logic [TimerW-1:0]    bus_timer;
    logic [CountW-1:0]    bus_pulses;
    logic                 bus_stop_ok;
    logic [OutcomeW-1:0]  bus_outcome;
    logic [TotalW-1:0]    bus_attempts;
    logic [TotalW-1:0]    bus_failures;

    t_result              ticks_awaiting_result[$];
    int                   mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // One tick of a fixed-length low or high phase; true once it has run out.
    function automatic logic half_period_over();
        bus_timer = bus_timer + 1'b1;
        return bus_timer >= {8'd0, bus_cfg.half};
    endfunction

    function automatic void pulse_or_stop(input logic sda);
        bus_timer = '0;
        if (!sda && bus_pulses < bus_cfg.pulses) begin
            bus_phase = PH_PULSE_LOW;
        end else begin
            bus_phase = PH_STOP_LOW;
        end
    endfunction

    function automatic logic conclude(input logic [OutcomeW-1:0] code);
        bus_outcome = code;
        if (code != OUT_IDLE && code != OUT_RECOVERED) begin
            bus_failures = bus_failures + 1'b1;
        end
        bus_phase = PH_IDLE;
        bus_timer = '0;
        return 1'b1;
    endfunction

    function automatic t_result advance_recovery(input logic start, input logic sda,
                                                 input logic scl);
        t_result             res;
        logic                done;
        logic                scl_ok;
        logic [OutcomeW-1:0] code;
        done = 1'b0;
        case (bus_phase)
            PH_IDLE: begin
                if (start) begin
                    bus_attempts = bus_attempts + 1'b1;
                    bus_pulses   = '0;
                    bus_stop_ok  = 1'b1;
                    bus_timer    = '0;
                    bus_phase    = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (bus_timer < {8'd0, bus_cfg.settle}) begin
                    bus_timer = bus_timer + 1'b1;
                end else if (sda && scl) begin
                    done = conclude(OUT_IDLE);
                end else if (!scl) begin
                    bus_timer = '0;
                    bus_phase = PH_STUCK_WAIT;
                end else begin
                    pulse_or_stop(sda);
                end
            end
            PH_STUCK_WAIT: begin
                if (scl) begin
                    pulse_or_stop(sda);
                end else if (bus_timer >= bus_cfg.stuck) begin
                    done = conclude(OUT_SCL_STUCK);
                end else begin
                    bus_timer = bus_timer + 1'b1;
                end
            end
            PH_PULSE_LOW: begin
                if (half_period_over()) begin
                    bus_timer = '0;
                    bus_phase = PH_PULSE_WAIT;
                end
            end
            PH_PULSE_WAIT: begin
                if (scl) begin
                    bus_timer = '0;
                    bus_phase = PH_PULSE_HIGH;
                end else if (bus_timer >= bus_cfg.stretch) begin
                    // The stretched pulse does not count; go straight to the STOP.
                    bus_timer = '0;
                    bus_phase = PH_STOP_LOW;
                end else begin
                    bus_timer = bus_timer + 1'b1;
                end
            end
            PH_PULSE_HIGH: begin
                if (half_period_over()) begin
                    bus_pulses = bus_pulses + 1'b1;
                    pulse_or_stop(sda);
                end
            end
            PH_STOP_LOW: begin
                if (half_period_over()) begin
                    bus_timer = '0;
                    bus_phase = PH_STOP_WAIT;
                end
            end
            PH_STOP_WAIT: begin
                if (scl) begin
                    bus_timer = '0;
                    bus_phase = PH_STOP_HIGH;
                end else if (bus_timer >= bus_cfg.stretch) begin
                    bus_stop_ok = 1'b0;
                    bus_timer   = '0;
                    bus_phase   = PH_STOP_HIGH;
                end else begin
                    bus_timer = bus_timer + 1'b1;
                end
            end
            PH_STOP_HIGH: begin
                if (half_period_over()) begin
                    bus_timer = '0;
                    bus_phase = PH_STOP_RELEASE;
                end
            end
            PH_STOP_RELEASE: begin
                if (half_period_over()) begin
                    scl_ok = scl && bus_stop_ok;
                    if (sda && scl_ok) begin
                        code = OUT_RECOVERED;
                    end else if (!sda && !scl_ok) begin
                        code = OUT_BOTH_LOW;
                    end else if (!sda) begin
                        code = OUT_SDA_LOW;
                    end else begin
                        code = OUT_SCL_LOW;
                    end
                    done = conclude(code);
                end
            end
            default: begin
                bus_phase = PH_IDLE;
                bus_timer = '0;
            end
        endcase
        res.scl_pull_low  = (bus_phase == PH_PULSE_LOW);
        res.sda_pull_low  = (bus_phase == PH_STOP_LOW) || (bus_phase == PH_STOP_WAIT) ||
                            (bus_phase == PH_STOP_HIGH);
        res.busy_res      = (bus_phase != PH_IDLE);
        res.finished      = done;
        res.outcome       = bus_outcome;
        res.pulses_given  = bus_pulses;
        res.attempt_total = bus_attempts;
        res.failure_total = bus_failures;
        return res;
    endfunction

    function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                           input logic [CfgDataW-1:0] data);
        case (idx)
            CFG_SETTLE:  bus_cfg.settle  = data[7:0];
            CFG_HALF:    bus_cfg.half    = data[7:0];
            CFG_STUCK:   bus_cfg.stuck   = data;
            CFG_STRETCH: bus_cfg.stretch = data;
            CFG_PULSES:  bus_cfg.pulses  = data[CountW-1:0];
            default: ;
        endcase
    endfunction

    function automatic int field_differs(input string name, input logic [TotalW-1:0] want,
                                         input logic [TotalW-1:0] got);
        if (want === got) begin
            return 0;
        end
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            bus_cfg.settle  = RST_SETTLE;
            bus_cfg.half    = RST_HALF;
            bus_cfg.stuck   = RST_STUCK;
            bus_cfg.stretch = RST_STRETCH;
            bus_cfg.pulses  = RST_PULSES;
            bus_phase       = PH_IDLE;
            bus_timer       = '0;
            bus_pulses      = '0;
            bus_stop_ok     = 1'b1;
            bus_outcome     = OUT_IDLE;
            bus_attempts    = '0;
            bus_failures    = '0;
            ticks_awaiting_result.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_scl_pull_low, i_sda_pull_low, i_busy_res, i_finished, i_outcome,
                       i_pulses_given, i_attempt_total, i_failure_total};
                if (ticks_awaiting_result.size() == 0) begin
                    $display("%0t ns: result expected none, got %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = ticks_awaiting_result.pop_front();
                    mismatch_count += field_differs("scl_pull_low",
                                                    TotalW'(want.scl_pull_low),
                                                    TotalW'(got.scl_pull_low))
                                    + field_differs("sda_pull_low",
                                                    TotalW'(want.sda_pull_low),
                                                    TotalW'(got.sda_pull_low))
                                    + field_differs("busy_res", TotalW'(want.busy_res),
                                                    TotalW'(got.busy_res))
                                    + field_differs("finished", TotalW'(want.finished),
                                                    TotalW'(got.finished))
                                    + field_differs("outcome", TotalW'(want.outcome),
                                                    TotalW'(got.outcome))
                                    + field_differs("pulses_given",
                                                    TotalW'(want.pulses_given),
                                                    TotalW'(got.pulses_given))
                                    + field_differs("attempt_total", want.attempt_total,
                                                    got.attempt_total)
                                    + field_differs("failure_total", want.failure_total,
                                                    got.failure_total);
                end
            end
            // A tick taken on the same edge as a register write still sees the old setting.
            if (i_in_valid && i_in_ready) begin
                ticks_awaiting_result.push_back(
                    advance_recovery(i_start_req, i_sda_level, i_scl_level));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
        end
    end

endmodule

@@ sim/tb_i2c_bus_clear_sequencer.sv @@
`timescale 1ns / 100ps

module tb_i2c_bus_clear_sequencer;

    import i2cbc_pkg::*;

    // An index that no register answers to; the block must drop such a write.
    localparam logic [CfgIdxW-1:0] CFG_NONE = 3'd7;

    // Every input of the block starts at a known level.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]    i_cfg_index = CFG_SETTLE;
    logic [CfgDataW-1:0]   i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_start_req = 1'b0;
    logic                  i_sda_level = 1'b1;
    logic                  i_scl_level = 1'b1;
    logic                  i_out_ready = 1'b0;

    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_scl_pull_low;
    logic                  o_sda_pull_low;
    logic                  o_busy_res;
    logic                  o_finished;
    logic [OutcomeW-1:0]   o_outcome;
    logic [CountW-1:0]     o_pulses_given;
    logic [TotalW-1:0]     o_attempt_total;
    logic [TotalW-1:0]     o_failure_total;

    // Percentages of cycles in which the tick source holds off and the result
    // sink refuses a transaction. Zero means no idling on that side.
    int                    sender_idle_pct    = 0;
    int                    receiver_stall_pct = 0;

    // Ticks handed over and results taken; their difference is what is still in flight.
    int                    ticks_sent   = 0;
    int                    results_seen = 0;
    logic                  last_busy    = 1'b0;
    int                    mismatches;

    always #4 i_clk = ~i_clk;

    i2c_bus_clear_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_req     (i_start_req),
        .i_sda_level     (i_sda_level),
        .i_scl_level     (i_scl_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scl_pull_low  (o_scl_pull_low),
        .o_sda_pull_low  (o_sda_pull_low),
        .o_busy_res      (o_busy_res),
        .o_finished      (o_finished),
        .o_outcome       (o_outcome),
        .o_pulses_given  (o_pulses_given),
        .o_attempt_total (o_attempt_total),
        .o_failure_total (o_failure_total)
    );

    i2c_bus_clear_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_start_req     (i_start_req),
        .i_sda_level     (i_sda_level),
        .i_scl_level     (i_scl_level),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_scl_pull_low  (o_scl_pull_low),
        .i_sda_pull_low  (o_sda_pull_low),
        .i_busy_res      (o_busy_res),
        .i_finished      (o_finished),
        .i_outcome       (o_outcome),
        .i_pulses_given  (o_pulses_given),
        .i_attempt_total (o_attempt_total),
        .i_failure_total (o_failure_total),
        .o_mismatches    (mismatches)
    );

    // Result sink. Ready is redrawn every cycle, which is legal on the sink side.
    // It also counts the result transactions taken and remembers whether the
    // newest one still showed a recovery in progress.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            last_busy    <= o_busy_res;
        end
    end

    // Hands one tick to the block. An optional random hold-off comes first, so
    // valid is only ever lowered before a tick and never while one is offered.
    // Once raised, valid and the levels stay put until the transaction is taken.
    task automatic send_tick(input logic start, input logic sda, input logic scl);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_start_req <= start;
        i_sda_level <= sda;
        i_scl_level <= scl;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    // Register write on the configuration channel. Valid is left high so that
    // back-to-back writes do not lower and raise it in the same step; the caller
    // drops it after the last write.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes all five registers. The unused upper bits of the narrow registers
    // carry junk, which the block has to mask off, and a write to an index that
    // does not exist is thrown in as well.
    task automatic write_settings(input int settle, input int half, input int stuck,
                                  input int stretch, input int pulses);
        logic [CfgDataW-1:0] junk;
        junk = CfgDataW'($urandom);
        write_reg(CFG_SETTLE, {junk[15:8], settle[7:0]});
        write_reg(CFG_HALF, {junk[7:0], half[7:0]});
        write_reg(CFG_STUCK, stuck[15:0]);
        write_reg(CFG_STRETCH, stretch[15:0]);
        write_reg(CFG_PULSES, {junk[15:4], pulses[3:0]});
        write_reg(CFG_NONE, junk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops the tick source until every result transaction has come back. If
    // the newest result still shows a recovery running, released-bus ticks are
    // fed until the sequencer reports idle, so that registers are only ever
    // written while it sits in its idle phase.
    task automatic drain_sequencer();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        forever begin
            while (results_seen != ticks_sent) @(posedge i_clk);
            if (!last_busy) break;
            send_tick(1'b0, 1'b1, 1'b1);
            i_in_valid <= 1'b0;
        end
    endtask

    // How long a line stays low after a start request: released at once, after a
    // few ticks, somewhere within the phase's time scale, or for good.
    function automatic int pick_hold(input int hold_max);
        case ($urandom_range(3))
            0:       return 0;
            1:       return $urandom_range(3);
            2:       return $urandom_range(hold_max);
            default: return 4 * hold_max + 20;
        endcase
    endfunction

    // Random recovery traffic. Most sequences model a bus that starts out hung
    // and then lets go: a start request, then SDA held low by a stuck target for
    // a while, SCL held low at first and later stretched at random. About one
    // in ten sequences is pure line noise instead, and now and then a start
    // request lands while a recovery is still running.
    task automatic run_traffic(input int n_ticks, input int hold_max);
        int   sent;
        int   len;
        int   sda_hold;
        int   scl_hold;
        int   stretch_pct;
        int   k;
        logic noisy;
        logic sda;
        logic scl;
        sent = 0;
        while (sent < n_ticks) begin
            len         = $urandom_range(2 * hold_max + 10, 4);
            noisy       = ($urandom_range(9) == 0);
            sda_hold    = pick_hold(hold_max);
            scl_hold    = pick_hold(hold_max);
            stretch_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 5 : 30);
            send_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
            for (k = 0; k < len; k++) begin
                if (noisy) begin
                    sda = 1'($urandom_range(1));
                    scl = 1'($urandom_range(1));
                end else begin
                    sda = (k >= sda_hold);
                    scl = (k >= scl_hold) && ($urandom_range(99) >= stretch_pct);
                end
                send_tick($urandom_range(99) < 3, sda, scl);
            end
            sent += len + 1;
        end
    endtask

    // One stretch of random traffic under one register setting and one idling
    // pattern. The drain in front also gives the pause with nothing in flight.
    task automatic run_phase(input int settle, input int half, input int stuck,
                             input int stretch, input int pulses, input int send_pct,
                             input int stall_pct, input int n_ticks, input int hold_max);
        drain_sequencer();
        write_settings(settle, half, stuck, stretch, pulses);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        run_traffic(n_ticks, hold_max);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the shortest timings, so that each case is a
        // handful of ticks: no settle wait, zero half period (acts as one tick),
        // a stuck timeout of one tick, no stretch tolerance and two pulses at most.
        write_settings(0, 0, 1, 0, 2);

        // Both lines high after the settle wait: the bus is already idle.
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);

        // SCL never rises: the stuck timeout fails the sequence. The start
        // request on the last tick arrives while busy and has to be ignored.
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);

        // SDA held low: one full pulse, then the second pulse is stretched past
        // the timeout and not counted. The STOP is stretched as well, so the
        // final check reports SCL low even though both lines read high.
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);

        // With zero pulses allowed the STOP follows at once; both lines are
        // low at the final check.
        drain_sequencer();
        write_reg(CFG_PULSES, '0);
        i_cfg_valid <= 1'b0;
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);

        // Random part. Settings run from the low extremes to the high extremes
        // and back to the reset values; idling goes through none, source only,
        // sink only and both at once.
        run_phase(2, 1, 6, 3, 4, 0, 0, 170, 8);
        run_phase(0, 0, 0, 0, 1, 53, 0, 170, 4);
        run_phase(255, 255, 65535, 65535, 15, 0, 53, 300, 300);
        run_phase(3, 2, 12, 5, 15, 10, 10, 170, 12);
        run_phase(RST_SETTLE, RST_HALF, RST_STUCK, RST_STRETCH, RST_PULSES, 0, 0, 120, 40);

        // Let everything in flight come back, then keep the sink open a little
        // longer so that a stray result transaction would still be caught.
        drain_sequencer();
        receiver_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && results_seen == ticks_sent) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the long STOP and
    // pulse phases of the widest settings under heavy stalling.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/i2cbc_pkg.sv
sv/i2cbc_core.sv
sv/i2cbc_out_reg.sv
sv/i2c_bus_clear_sequencer.sv
sim/i2c_bus_clear_checker.sv
sim/tb_i2c_bus_clear_sequencer.sv
